// ===== design/opht_pkg.sv =====
// Shared types and constants for the object position history table.
// Used by the front, back, top and checker modules; depends on nothing else.
package opht_pkg;

    localparam int OPHT_SLOTS = 256;
    localparam logic [15:0] STALE_LIMIT_RESET = 16'd4;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_KEY_ZERO = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_PREV  = 2'd3
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [63:0] object_key;
        logic [31:0] step_stamp;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic [31:0] prev_z;
        logic [31:0] step_gap;
    } t_res;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] last_frame;
        logic [31:0] stamp;
        logic [31:0] gap;
        logic        has_prev;
    } t_meta;

    typedef struct packed {
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic [31:0] prev_z;
        logic [31:0] cur_x;
        logic [31:0] cur_y;
        logic [31:0] cur_z;
    } t_pos;

endpackage

// ===== design/opht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the slot stores.
module opht_ram #(
    parameter int W = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/opht_fifo.sv =====
// Small register queue of generic width, two words deep.
// Self-contained; used between front and back and on the result side.
module opht_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    logic [W-1:0] r_data [2];
    logic         r_head;
    logic         n_head;
    logic [1:0]   r_count;
    logic [1:0]   n_count;
    logic         do_push;
    logic         do_pop;
    logic         wr_idx;

    assign o_full = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign wr_idx = r_head ^ r_count[0];
    assign o_rdata = r_data[r_head];

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        if (do_pop) begin
            n_head = !r_head;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[wr_idx] <= i_wdata;
        end
    end
endmodule

// ===== design/opht_front.sv =====
// Front end: takes one input word, hashes the low 32 key bits and reduces that modulo
// the slot count. Depends on opht_pkg; feeds the command queue.
module opht_front #(
    parameter int SLOTS = opht_pkg::OPHT_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  opht_pkg::t_cmd                    i_cmd,
    output logic                              o_full,
    output logic                              o_q_push,
    output logic [$bits(opht_pkg::t_cmd)+$clog2(SLOTS)-1:0] o_q_data,
    input  logic                              i_q_full
);
    import opht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int K = 32 + AW;
    localparam logic [32:0] RECIP = 33'(((64'd1 << K) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [AW-1:0] SLOTS_LO = AW'(SLOTS);

    t_cmd          r_cmd;
    logic          r_busy;
    logic [2:0]    r_steps;
    logic [31:0]   r_m;
    logic [64:0]   r_prod;
    logic [AW-1:0] r_rem;
    logic [31:0]   hash1;
    logic [31:0]   hash2;
    logic [31:0]   quot;
    logic          accept;

    assign accept = i_push && !r_busy;
    assign o_full = r_busy;
    assign o_q_push = r_busy && (r_steps == 3'd2);
    assign o_q_data = {r_cmd, r_rem};
    assign hash1 = i_cmd.object_key[31:0] ^ (i_cmd.object_key[31:0] >> 4);
    assign hash2 = hash1 ^ (hash1 >> 12);
    assign quot = 32'(r_prod >> K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_steps <= 3'd0;
        end else if (accept) begin
            r_busy <= 1'b1;
            if (i_cmd.req_type == REQ_SAMPLE && i_cmd.object_key != 64'd0) begin
                r_steps <= 3'd0;
            end else begin
                r_steps <= 3'd2;
            end
        end else if (r_busy && r_steps != 3'd2) begin
            r_steps <= r_steps + 3'd1;
        end else if (o_q_push && !i_q_full) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_m <= hash2;
            r_rem <= '0;
        end else if (r_busy && r_steps == 3'd0) begin
            r_prod <= 65'(r_m) * 65'(RECIP);
        end else if (r_busy && r_steps == 3'd1) begin
            r_rem <= r_m[AW-1:0] - AW'(quot[AW-1:0] * SLOTS_LO);
        end
    end
endmodule

// ===== design/opht_back.sv =====
// Back end: clears the key store after reset, probes slots and updates entries.
// Depends on opht_pkg and opht_ram; reads the command queue, writes the result queue.
module opht_back #(
    parameter int SLOTS = opht_pkg::OPHT_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [15:0]                       i_stale_limit,
    input  logic                              i_q_empty,
    input  logic [$bits(opht_pkg::t_cmd)+$clog2(SLOTS)-1:0] i_q_data,
    output logic                              o_q_pop,
    output logic                              o_res_push,
    output opht_pkg::t_res                    o_res,
    input  logic                              i_res_full
);
    import opht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_CHK  = 6'b001000,
        S_POS  = 6'b010000,
        S_UPD  = 6'b100000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    t_cmd          r_cmd;
    t_cmd          q_cmd;
    logic [AW-1:0] q_home;
    logic [31:0]   r_frame;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] n_cnt;
    logic          r_sf;
    logic          n_sf;
    logic [AW-1:0] r_sidx;
    logic [AW-1:0] n_sidx;
    t_meta         r_smeta;
    t_meta         n_smeta;
    logic [AW-1:0] r_slot;
    logic [AW-1:0] n_slot;
    t_meta         r_meta;
    t_meta         n_meta;
    t_meta         rd_meta;
    t_pos          rd_pos;
    t_meta         wr_meta;
    t_pos          wr_pos;
    logic          meta_we;
    logic [AW-1:0] meta_waddr;
    logic          pos_we;
    logic          hit;
    logic          stale;
    logic          frame_inc;
    t_res          res;

    assign q_cmd = t_cmd'(i_q_data[$bits(t_cmd)+AW-1:AW]);
    assign q_home = i_q_data[AW-1:0];
    assign hit = (rd_meta.key == r_cmd.object_key) || (rd_meta.key == 64'd0);
    assign stale = (r_frame - rd_meta.last_frame) > {16'd0, i_stale_limit};

    opht_ram #(.W($bits(t_meta)), .DEPTH(SLOTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (wr_meta),
        .i_raddr (r_idx),
        .o_rdata (rd_meta)
    );

    opht_ram #(.W($bits(t_pos)), .DEPTH(SLOTS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (r_slot),
        .i_wdata (wr_pos),
        .i_raddr (r_slot),
        .o_rdata (rd_pos)
    );

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_cnt = r_cnt;
        n_sf = r_sf;
        n_sidx = r_sidx;
        n_smeta = r_smeta;
        n_slot = r_slot;
        n_meta = r_meta;
        o_q_pop = 1'b0;
        o_res_push = 1'b0;
        res = '0;
        meta_we = 1'b0;
        meta_waddr = r_slot;
        wr_meta = '0;
        pos_we = 1'b0;
        wr_pos = rd_pos;
        frame_inc = 1'b0;
        case (r_state)
            S_CLR: begin
                meta_we = 1'b1;
                meta_waddr = r_idx;
                if (r_idx == LAST) begin
                    n_idx = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_IDLE: begin
                if (!i_q_empty && !i_res_full) begin
                    o_q_pop = 1'b1;
                    if (q_cmd.req_type == REQ_TICK) begin
                        frame_inc = 1'b1;
                    end else if (q_cmd.object_key == 64'd0) begin
                        o_res_push = 1'b1;
                        res.status = ST_KEY_ZERO;
                    end else begin
                        n_idx = q_home;
                        n_cnt = '0;
                        n_sf = 1'b0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (hit) begin
                    n_slot = r_idx;
                    n_meta = rd_meta;
                    n_state = S_POS;
                end else begin
                    if (!r_sf && stale) begin
                        n_sf = 1'b1;
                        n_sidx = r_idx;
                        n_smeta = rd_meta;
                    end
                    if (r_cnt == LAST) begin
                        if (r_sf) begin
                            n_slot = r_sidx;
                            n_meta = r_smeta;
                            n_state = S_POS;
                        end else if (stale) begin
                            n_slot = r_idx;
                            n_meta = rd_meta;
                            n_state = S_POS;
                        end else begin
                            o_res_push = 1'b1;
                            res.status = ST_FULL;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                        n_idx = (r_idx == LAST) ? '0 : r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_POS: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                meta_we = 1'b1;
                pos_we = 1'b1;
                wr_meta = r_meta;
                wr_meta.last_frame = r_frame;
                if (r_meta.key != r_cmd.object_key) begin
                    wr_meta.key = r_cmd.object_key;
                    wr_meta.stamp = r_cmd.step_stamp;
                    wr_meta.gap = 32'd1;
                    wr_meta.has_prev = 1'b0;
                    wr_pos.cur_x = r_cmd.pos_x;
                    wr_pos.cur_y = r_cmd.pos_y;
                    wr_pos.cur_z = r_cmd.pos_z;
                end else if (r_meta.stamp != r_cmd.step_stamp) begin
                    wr_meta.gap = r_cmd.step_stamp - r_meta.stamp;
                    wr_meta.stamp = r_cmd.step_stamp;
                    wr_meta.has_prev = 1'b1;
                    wr_pos.prev_x = rd_pos.cur_x;
                    wr_pos.prev_y = rd_pos.cur_y;
                    wr_pos.prev_z = rd_pos.cur_z;
                    wr_pos.cur_x = r_cmd.pos_x;
                    wr_pos.cur_y = r_cmd.pos_y;
                    wr_pos.cur_z = r_cmd.pos_z;
                end
                o_res_push = 1'b1;
                if (wr_meta.has_prev) begin
                    res.status = ST_OK;
                    res.prev_x = wr_pos.prev_x;
                    res.prev_y = wr_pos.prev_y;
                    res.prev_z = wr_pos.prev_z;
                    res.step_gap = wr_meta.gap;
                end else begin
                    res.status = ST_NO_PREV;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx <= '0;
            r_frame <= 32'd0;
            r_cnt <= '0;
            r_sf <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_cnt <= n_cnt;
            r_sf <= n_sf;
            if (frame_inc) begin
                r_frame <= r_frame + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= q_cmd;
        end
        r_sidx <= n_sidx;
        r_smeta <= n_smeta;
        r_slot <= n_slot;
        r_meta <= n_meta;
    end
endmodule

// ===== design/object_position_history_table.sv =====
// Keyed position history table. The front hashes a sample's key and reduces it modulo the
// slot count; the back then probes slots, with a read and a check state per probed slot,
// then reads positions and updates the entry, which sets the throughput. A frame tick is
// handled in the idle state of the back. Synchronous active-low reset; after reset the back
// clears every slot of the key store while words wait.
module object_position_history_table #(
    parameter int SLOTS = opht_pkg::OPHT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [63:0] i_object_key,
    input  logic [31:0] i_step_stamp,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_prev_x,
    output logic [31:0] o_prev_y,
    output logic [31:0] o_prev_z,
    output logic [31:0] o_step_gap,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import opht_pkg::*;

    localparam int QW = $bits(t_cmd) + $clog2(SLOTS);

    t_cmd        in_cmd;
    logic        q_push;
    logic [QW-1:0] q_wdata;
    logic        q_full;
    logic        q_pop;
    logic [QW-1:0] q_rdata;
    logic        q_empty;
    logic        res_push;
    t_res        res_in;
    logic        res_full;
    t_res        res_out;
    logic [15:0] r_stale_limit;

    assign in_cmd = '{req_type: i_req_type, object_key: i_object_key,
                      step_stamp: i_step_stamp, pos_x: i_pos_x, pos_y: i_pos_y,
                      pos_z: i_pos_z};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= STALE_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_stale_limit <= i_cfg_data;
        end
    end

    opht_front #(.SLOTS(SLOTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (in_cmd),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    opht_fifo #(.W(QW)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    opht_back #(.SLOTS(SLOTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stale_limit (r_stale_limit),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .o_res_push    (res_push),
        .o_res         (res_in),
        .i_res_full    (res_full)
    );

    opht_fifo #(.W($bits(t_res))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign o_status = res_out.status;
    assign o_prev_x = res_out.prev_x;
    assign o_prev_y = res_out.prev_y;
    assign o_prev_z = res_out.prev_z;
    assign o_step_gap = res_out.step_gap;
endmodule

// ===== design/opht_checker.sv =====
// Port-level checks for the object position history table, attached by bind.
// Depends on opht_pkg for the status codes.
module opht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [31:0] o_prev_x,
    input logic [31:0] o_prev_y,
    input logic [31:0] o_prev_z,
    input logic [31:0] o_step_gap
);
    import opht_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("Result queue not empty after reset.");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("Input side full after reset.");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |->
        (o_prev_x == 32'd0 && o_prev_y == 32'd0 && o_prev_z == 32'd0 &&
         o_step_gap == 32'd0))
        else $error("Fields not zero on a result without a previous position.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_step_gap)))
        else $error("Waiting result changed before it was taken.");
endmodule

bind object_position_history_table opht_checker u_opht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_status   (o_status),
    .o_prev_x   (o_prev_x),
    .o_prev_y   (o_prev_y),
    .o_prev_z   (o_prev_z),
    .o_step_gap (o_step_gap)
);
